### hw/rtl/ssr_pkg.sv
// -----------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants of the streaming find-and-replace unit.
// -----------------------------------------------------------------------------
package ssr_pkg;

    localparam int BYTE_W      = 8;
    localparam int FIELD_BYTES = 8;    // bytes packed in a 64-bit config word
    localparam int WORD_W      = BYTE_W * FIELD_BYTES;
    localparam int LEN_W       = 4;
    localparam int CNT_W       = 4;    // result count of one request, up to 8
    localparam int CFG_IDX_W   = 2;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [LEN_W-1:0]     t_len;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // configuration register indexes
    localparam t_cfg_idx REG_PAT_BYTES = 2'd0;
    localparam t_cfg_idx REG_PAT_LEN   = 2'd1;
    localparam t_cfg_idx REG_REP_BYTES = 2'd2;
    localparam t_cfg_idx REG_REP_LEN   = 2'd3;

    // control part of one queued run of results
    typedef struct packed {
        logic [CNT_W-1:0] count;   // results in the run, 1..8 when valid
        logic             bare;    // single end marker without a character
        logic             eot;     // run closes the string
    } t_run_ctl;

endpackage

### hw/rtl/ssr_if.sv
// -----------------------------------------------------------------------------
// ssr_if
// Valid/ready channels of the find-and-replace unit: text in, text out, config.
// -----------------------------------------------------------------------------
interface ssr_in_if;
    import ssr_pkg::*;
    logic  valid;
    logic  ready;
    t_byte text_byte;
    logic  end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ssr_out_if;
    import ssr_pkg::*;
    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  byte_present;
    logic  last_of_run;
    logic  end_of_output;

    modport source (output valid, output out_byte, output byte_present,
                    output last_of_run, output end_of_output, input ready);
    modport sink   (input valid, input out_byte, input byte_present,
                    input last_of_run, input end_of_output, output ready);
endinterface

interface ssr_cfg_if;
    import ssr_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_word    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/ssr_match.sv
// -----------------------------------------------------------------------------
// ssr_match
// One step of the matcher: appends a byte to the held prefix, finds the
// earliest start still agreeing with the pattern, builds the run of results
// and the next held prefix.
// -----------------------------------------------------------------------------
module ssr_match #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  ssr_pkg::t_word    i_pat_bytes,
    input  logic [$clog2(((MAX_PATTERN < ssr_pkg::FIELD_BYTES) ? MAX_PATTERN
                          : ssr_pkg::FIELD_BYTES) + 1)-1:0] i_pat_len,
    input  ssr_pkg::t_word    i_rep_bytes,
    input  logic [ssr_pkg::CNT_W-1:0] i_rep_len,
    input  ssr_pkg::t_byte    i_held [((MAX_PATTERN < ssr_pkg::FIELD_BYTES) ? MAX_PATTERN
                                       : ssr_pkg::FIELD_BYTES)],
    input  logic [$clog2(((MAX_PATTERN < ssr_pkg::FIELD_BYTES) ? MAX_PATTERN
                          : ssr_pkg::FIELD_BYTES) + 1)-1:0] i_held_cnt,
    input  ssr_pkg::t_byte    i_byte,
    input  logic              i_eot,
    output ssr_pkg::t_byte    o_bytes [((MAX_PATTERN < ssr_pkg::FIELD_BYTES) ? MAX_PATTERN
                                        : ssr_pkg::FIELD_BYTES) >
                                       ((MAX_REPLACEMENT < ssr_pkg::FIELD_BYTES)
                                        ? MAX_REPLACEMENT : ssr_pkg::FIELD_BYTES)
                                       ? ((MAX_PATTERN < ssr_pkg::FIELD_BYTES)
                                          ? MAX_PATTERN : ssr_pkg::FIELD_BYTES)
                                       : ((MAX_REPLACEMENT < ssr_pkg::FIELD_BYTES)
                                          ? MAX_REPLACEMENT : ssr_pkg::FIELD_BYTES)],
    output ssr_pkg::t_run_ctl o_ctl,
    output ssr_pkg::t_byte    o_held [((MAX_PATTERN < ssr_pkg::FIELD_BYTES) ? MAX_PATTERN
                                       : ssr_pkg::FIELD_BYTES)],
    output logic [$clog2(((MAX_PATTERN < ssr_pkg::FIELD_BYTES) ? MAX_PATTERN
                          : ssr_pkg::FIELD_BYTES) + 1)-1:0] o_held_cnt
);
    import ssr_pkg::*;

    localparam int PAT_LIM = (MAX_PATTERN < FIELD_BYTES) ? MAX_PATTERN : FIELD_BYTES;
    localparam int REP_LIM = (MAX_REPLACEMENT < FIELD_BYTES) ? MAX_REPLACEMENT
                                                             : FIELD_BYTES;
    localparam int RUN_D   = (PAT_LIM > REP_LIM) ? PAT_LIM : REP_LIM;
    localparam int HC_W    = $clog2(PAT_LIM + 1);

    t_byte             buf_b [PAT_LIM];
    logic [HC_W-1:0]   h;
    logic [HC_W-1:0]   n;
    logic [HC_W-1:0]   s_sel;
    logic [PAT_LIM-1:0] ok;
    logic              matched;
    logic [CNT_W-1:0]  run_cnt;

    // a held count not below the pattern length cannot be a proper prefix
    assign h = (i_held_cnt >= i_pat_len) ? '0 : i_held_cnt;
    assign n = h + HC_W'(1);

    always_comb begin
        for (int i = 0; i < PAT_LIM; i++) begin
            buf_b[i] = (HC_W'(i) < h) ? i_held[i] : i_byte;
        end
    end

    // ok[s]: buffer tail from s agrees with the pattern head
    always_comb begin
        for (int s = 0; s < PAT_LIM; s++) begin
            ok[s] = (HC_W'(s) <= h);
            for (int j = 0; j < PAT_LIM; j++) begin
                if (s + j < PAT_LIM) begin
                    if ((HC_W'(s + j) <= h) &&
                        (buf_b[s + j] != i_pat_bytes[BYTE_W*j +: BYTE_W])) begin
                        ok[s] = 1'b0;
                    end
                end
            end
        end
    end

    // earliest agreeing start; n when none
    always_comb begin
        s_sel = n;
        for (int s = PAT_LIM - 1; s >= 0; s--) begin
            if (ok[s]) begin
                s_sel = HC_W'(s);
            end
        end
    end

    assign matched = (s_sel == '0) && (n == i_pat_len);

    // next held prefix: buffer shifted down by the released byte count
    always_comb begin
        for (int k = 0; k < PAT_LIM; k++) begin
            o_held[k] = buf_b[k];
            for (int v = 1; v < PAT_LIM; v++) begin
                if ((s_sel == HC_W'(v)) && (k + v < PAT_LIM)) begin
                    o_held[k] = buf_b[k + v];
                end
            end
        end
    end

    assign o_held_cnt = (matched || i_eot) ? '0 : (n - s_sel);

    // run: replacement on a match, whole buffer at end of string, else released head
    always_comb begin
        for (int k = 0; k < RUN_D; k++) begin
            if (matched) begin
                o_bytes[k] = (k < REP_LIM) ? i_rep_bytes[BYTE_W*k +: BYTE_W] : '0;
            end else begin
                o_bytes[k] = (k < PAT_LIM) ? buf_b[k] : '0;
            end
        end
    end

    always_comb begin
        if (matched) begin
            run_cnt = i_rep_len;
        end else if (i_eot) begin
            run_cnt = CNT_W'(n);
        end else begin
            run_cnt = CNT_W'(s_sel);
        end
        o_ctl.eot   = i_eot;
        o_ctl.bare  = i_eot && (run_cnt == '0);
        o_ctl.count = o_ctl.bare ? CNT_W'(1) : run_cnt;
    end

endmodule

### hw/rtl/stream_substring_replace_unit.sv
// -----------------------------------------------------------------------------
// stream_substring_replace_unit
// Streaming find-and-replace of a configured 1..8 byte pattern.
// -----------------------------------------------------------------------------
// Bytes enter through a one-entry input register and are matched in one pass
// into a result register that holds the whole run of results of that byte
// (released bytes, the replacement, or the flush at end of string). The result
// register hands out one result per cycle while the output is ready; a byte's
// run enters it only once the previous run has gone or its last result leaves.
// Bytes held as a possible match start and bytes yielding one result stream
// at one per cycle while the output is ready. The first result is offered once
// its byte has passed the input register and the matcher. Config writes are
// always accepted; writing the pattern or its length drops the held bytes.
module stream_substring_replace_unit #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssr_in_if.sink    i_in,
    ssr_out_if.source o_out,
    ssr_cfg_if.sink   i_cfg
);
    import ssr_pkg::*;

    localparam int PAT_LIM = (MAX_PATTERN < FIELD_BYTES) ? MAX_PATTERN : FIELD_BYTES;
    localparam int REP_LIM = (MAX_REPLACEMENT < FIELD_BYTES) ? MAX_REPLACEMENT
                                                             : FIELD_BYTES;
    localparam int RUN_D   = (PAT_LIM > REP_LIM) ? PAT_LIM : REP_LIM;
    localparam int HC_W    = $clog2(PAT_LIM + 1);
    localparam int IDX_W   = (RUN_D > 1) ? $clog2(RUN_D) : 1;

    // config
    t_word            r_pat_bytes;
    t_len             r_pat_len;
    t_word            r_rep_bytes;
    t_len             r_rep_len;
    logic [HC_W-1:0]  pat_len_c;
    logic [CNT_W-1:0] rep_len_c;

    // input register
    logic  r_in_valid;
    t_byte r_in_byte;
    logic  r_in_eot;

    // held prefix
    t_byte           r_held [PAT_LIM];
    logic [HC_W-1:0] r_held_cnt;

    // result register
    logic       r_b_valid;
    t_run_ctl   r_b_ctl;
    t_byte      r_b_bytes [RUN_D];
    logic [IDX_W-1:0] r_b_idx;

    // matcher outputs
    t_byte           m_bytes [RUN_D];
    t_run_ctl        m_ctl;
    t_byte           m_held [PAT_LIM];
    logic [HC_W-1:0] m_held_cnt;

    logic in_take, out_take, out_last, run_free, advance;

    always_comb begin
        if (r_pat_len == '0) begin
            pat_len_c = HC_W'(1);
        end else if (r_pat_len > LEN_W'(PAT_LIM)) begin
            pat_len_c = HC_W'(PAT_LIM);
        end else begin
            pat_len_c = HC_W'(r_pat_len);
        end
        rep_len_c = (r_rep_len > LEN_W'(REP_LIM)) ? CNT_W'(REP_LIM) : CNT_W'(r_rep_len);
    end

    ssr_match #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_match (
        .i_pat_bytes (r_pat_bytes),
        .i_pat_len   (pat_len_c),
        .i_rep_bytes (r_rep_bytes),
        .i_rep_len   (rep_len_c),
        .i_held      (r_held),
        .i_held_cnt  (r_held_cnt),
        .i_byte      (r_in_byte),
        .i_eot       (r_in_eot),
        .o_bytes     (m_bytes),
        .o_ctl       (m_ctl),
        .o_held      (m_held),
        .o_held_cnt  (m_held_cnt)
    );

    assign out_last = (CNT_W'(r_b_idx) + CNT_W'(1)) == r_b_ctl.count;
    assign out_take = r_b_valid && o_out.ready;
    assign run_free = !r_b_valid || (o_out.ready && out_last);
    assign advance  = r_in_valid && run_free;
    assign i_in.ready = !r_in_valid || run_free;
    assign in_take  = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = r_b_valid;
    assign o_out.out_byte      = r_b_ctl.bare ? '0 : r_b_bytes[r_b_idx];
    assign o_out.byte_present  = !r_b_ctl.bare;
    assign o_out.last_of_run   = out_last;
    assign o_out.end_of_output = out_last && r_b_ctl.eot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_b_valid   <= 1'b0;
            r_held_cnt  <= '0;
            r_pat_bytes <= '0;
            r_pat_len   <= LEN_W'(1);
            r_rep_bytes <= '0;
            r_rep_len   <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_in.text_byte;
                r_in_eot   <= i_in.end_of_text;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_held     <= m_held;
                r_held_cnt <= m_held_cnt;
                if (m_ctl.count != '0) begin
                    r_b_valid <= 1'b1;
                    r_b_ctl   <= m_ctl;
                    r_b_bytes <= m_bytes;
                    r_b_idx   <= '0;
                end else begin
                    r_b_valid <= 1'b0;
                end
            end else if (out_take) begin
                if (out_last) begin
                    r_b_valid <= 1'b0;
                end else begin
                    r_b_idx <= r_b_idx + IDX_W'(1);
                end
            end

            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_PAT_BYTES: begin
                        r_pat_bytes <= i_cfg.data;
                        r_held_cnt  <= '0;
                    end
                    REG_PAT_LEN: begin
                        r_pat_len  <= i_cfg.data[LEN_W-1:0];
                        r_held_cnt <= '0;
                    end
                    REG_REP_BYTES: r_rep_bytes <= i_cfg.data;
                    REG_REP_LEN:   r_rep_len   <= i_cfg.data[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### hw/rtl/ssr_checker.sv
// -----------------------------------------------------------------------------
// ssr_checker
// Port-level checks of the find-and-replace unit, bound to the top level.
// -----------------------------------------------------------------------------
module ssr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_in_eot,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input ssr_pkg::t_byte i_out_byte,
    input logic           i_out_present,
    input logic           i_out_last,
    input logic           i_out_end
);
    import ssr_pkg::*;

    // strings whose end was requested but not yet delivered
    logic [1:0] r_ends;
    logic [1:0] n_ends;
    logic       in_end, out_end;

    assign in_end  = i_in_valid && i_in_ready && i_in_eot;
    assign out_end = i_out_valid && i_out_ready && i_out_end;

    always_comb begin
        n_ends = r_ends;
        if (in_end && !out_end) begin
            n_ends = r_ends + 2'd1;
        end else if (out_end && !in_end) begin
            n_ends = r_ends - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ends <= '0;
        end else begin
            r_ends <= n_ends;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
        else $error("stalled result changed");

    a_end_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_end |-> r_ends != 2'd0)
        else $error("end of output without a requested end of text");

    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_present |-> i_out_end && i_out_last && r_ends != 2'd0)
        else $error("bare marker outside end of string");

endmodule

bind stream_substring_replace_unit ssr_checker u_ssr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_eot      (i_in.end_of_text),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_byte    (o_out.out_byte),
    .i_out_present (o_out.byte_present),
    .i_out_last    (o_out.last_of_run),
    .i_out_end     (o_out.end_of_output)
);

### dv/stream_substring_replace_unit_tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// stream_substring_replace_unit_tb
// Checks the find-and-replace unit against a cycle-free predictor of the
// rewritten text: directed cases first, then random strings built from pieces
// of the pattern and random bytes, under random stalls on both channels and config changes.
// -----------------------------------------------------------------------------
module stream_substring_replace_unit_tb;
    import ssr_pkg::*;

    localparam int PAT_MAX       = 8;
    localparam int REP_MAX       = 8;
    localparam int ITEM_TARGET   = 370;
    localparam int SETTLE_CYCLES = 8;
    localparam int STUCK_LIMIT   = 2000;
    localparam int RX_HOLD       = 300;

    typedef struct packed {
        t_byte ch;
        logic  present;
        logic  run_end;
        logic  text_end;
    } t_text_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ssr_in_if  in_ch ();
    ssr_out_if out_ch ();
    ssr_cfg_if cfg_ch ();

    stream_substring_replace_unit #(
        .MAX_PATTERN     (PAT_MAX),
        .MAX_REPLACEMENT (REP_MAX)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor copy of the config registers and the held prefix
    t_word pat_word  = '0;
    t_len  pat_len_r = 4'd1;
    t_word rep_word  = '0;
    t_len  rep_len_r = 4'd0;
    t_byte held_text [8];
    int    held_cnt  = 0;

    t_text_res pending_text_out [$];
    int        text_reqs    = 0;
    int        err_cnt      = 0;
    int        stuck_cycles = 0;
    int        rx_hold_req  = 0;
    bit        rx_stalls_on = 1'b1;
    bit        tx_gaps_on   = 1'b1;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic int eff_pat_len();
        int n;
        n = pat_len_r;
        if (n < 1) n = 1;
        if (n > PAT_MAX) n = PAT_MAX;
        return n;
    endfunction

    // expected results of one accepted text request
    task automatic predict_text(input t_byte b, input logic eot);
        t_byte     win [9];
        t_text_res run [8];
        int        plen, rlen, h, n, s, k;
        bit        ok, hit;
        plen = eff_pat_len();
        rlen = (rep_len_r > REP_MAX) ? REP_MAX : rep_len_r;
        h = (held_cnt >= plen) ? 0 : held_cnt;
        for (int i = 0; i < h; i++) win[i] = held_text[i];
        win[h] = b;
        n = h + 1;
        // leftmost start whose tail is still a pattern prefix
        for (s = 0; s < n; s++) begin
            ok = 1'b1;
            for (int i = s; i < n; i++) begin
                if (win[i] != pat_word[(i - s)*BYTE_W +: BYTE_W]) ok = 1'b0;
            end
            if (ok) break;
        end
        hit = (s == 0) && (n == plen);
        k = 0;
        if (hit) begin
            for (int i = 0; i < rlen; i++) begin
                run[k] = '{rep_word[i*BYTE_W +: BYTE_W], 1'b1, 1'b0, 1'b0};
                k++;
            end
            held_cnt = 0;
        end else begin
            for (int i = 0; i < s; i++) begin
                run[k] = '{win[i], 1'b1, 1'b0, 1'b0};
                k++;
            end
            held_cnt = n - s;
            for (int i = s; i < n; i++) held_text[i - s] = win[i];
        end
        if (eot) begin
            if (!hit) begin
                for (int i = 0; i < held_cnt; i++) begin
                    run[k] = '{held_text[i], 1'b1, 1'b0, 1'b0};
                    k++;
                end
            end
            held_cnt = 0;
            if (k == 0) begin
                run[0] = '{8'h00, 1'b0, 1'b0, 1'b0};
                k = 1;
            end
            run[k-1].text_end = 1'b1;
        end
        if (k > 0) run[k-1].run_end = 1'b1;
        for (int i = 0; i < k; i++) pending_text_out.push_back(run[i]);
    endtask

    // one text request; with no gap valid stays high, so back-to-back requests have no bubble
    task automatic send_text(input t_byte b, input logic eot);
        int gap;
        gap = tx_gaps_on ? rand_gap() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.text_byte   <= b;
        in_ch.end_of_text <= eot;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predict_text(b, eot);
        text_reqs++;
    endtask

    // low byte goes first
    task automatic send_bytes(input t_word w, input int n, input logic eot_on_last);
        for (int i = 0; i < n; i++) send_text(w[i*BYTE_W +: BYTE_W], eot_on_last && (i == n - 1));
    endtask

    task automatic settle_block();
        in_ch.valid <= 1'b0;
        while (pending_text_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_word val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_PAT_BYTES: begin
                pat_word = val;
                held_cnt = 0;
            end
            REG_PAT_LEN: begin
                pat_len_r = val[LEN_W-1:0];
                held_cnt  = 0;
            end
            REG_REP_BYTES: rep_word = val;
            REG_REP_LEN:   rep_len_r = val[LEN_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // length registers get random upper bits; only the low nibble counts
    task automatic write_len(input t_cfg_idx idx, input t_len len);
        t_word w;
        w = rand_word();
        w[LEN_W-1:0] = len;
        write_reg(idx, w);
    endtask

    task automatic set_config(input t_word pat, input t_len plen,
                              input t_word rep, input t_len rlen);
        write_reg(REG_PAT_BYTES, pat);
        write_len(REG_PAT_LEN, plen);
        write_reg(REG_REP_BYTES, rep);
        write_len(REG_REP_LEN, rlen);
    endtask

    // pattern 00, length 1, empty replacement: zeros vanish, last one leaves a bare end
    task automatic test_reset_defaults();
        send_bytes(64'h00_41_00, 3, 1'b1);
        settle_block();
    endtask

    task automatic test_partial_matches();
        set_config(64'h63_62_61, 4'd3, 64'h59_58, 4'd2);
        // restart after a broken prefix, a match, then a stray byte at the end
        send_bytes(64'h63_63_62_61_62_61, 6, 1'b1);
        // byte extremes, then a held prefix flushed at end of string
        send_bytes(64'h62_61_00_FF, 4, 1'b1);
        settle_block();
    endtask

    task automatic test_length_limits();
        // lengths above 8 act as 8: full-width match and full replacement
        set_config('1, 4'd15, 64'h0123_4567_89AB_CDEF, 4'd15);
        send_bytes('1, 8, 1'b1);
        settle_block();
        // length 0 acts as 1
        write_len(REG_PAT_LEN, 4'd0);
        send_bytes(64'h00_FF, 2, 1'b1);
        settle_block();
    endtask

    task automatic test_mid_string_rewrite();
        set_config(64'h63_62_61, 4'd3, 64'h59_58, 4'd2);
        send_bytes(64'h62_61, 2, 1'b0);
        settle_block();
        // new pattern drops the held prefix
        write_reg(REG_PAT_BYTES, 64'h7A_79_78);
        send_bytes(64'h63, 1, 1'b1);
        settle_block();
        write_reg(REG_PAT_BYTES, 64'h63_62_61);
        send_bytes(64'h61, 1, 1'b0);
        settle_block();
        // new replacement applies to the match already in progress
        write_reg(REG_REP_BYTES, 64'h5A);
        send_bytes(64'h63_62, 2, 1'b1);
        settle_block();
    endtask

    task automatic test_output_backpressure();
        t_byte key;
        set_config(rand_word(), 4'd1, rand_word(), 4'd8);
        key = pat_word[BYTE_W-1:0];
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        rx_hold_req  = RX_HOLD;
        // every other byte expands to eight, so the unit fills and stalls its input
        for (int i = 0; i < 40; i++) send_text((i % 2) ? key : t_byte'($urandom), i == 39);
        settle_block();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    task automatic test_random_streams();
        t_byte txt [$];
        t_word pat;
        t_len  plen_cfg, rlen_cfg;
        int    phase, phase_start, plen, sel, cnt, j, cut;
        bit    small_alpha;
        phase = 0;
        while (text_reqs < ITEM_TARGET) begin
            small_alpha = (phase % 4 == 0);
            case (phase % 4)
                0: begin
                    // two-letter alphabet gives self-overlapping patterns
                    for (int i = 0; i < FIELD_BYTES; i++)
                        pat[i*BYTE_W +: BYTE_W] = t_byte'(8'h61 + $urandom_range(0, 1));
                end
                1: pat = rand_word();
                2: pat = '1;
                default: pat = '0;
            endcase
            case (phase % 6)
                0: plen_cfg = 4'd1;
                1: plen_cfg = 4'd8;
                2: plen_cfg = 4'd0;
                3: plen_cfg = 4'd15;
                default: plen_cfg = t_len'($urandom_range(1, 8));
            endcase
            case (phase % 5)
                0: rlen_cfg = 4'd0;
                1: rlen_cfg = 4'd8;
                2: rlen_cfg = 4'd15;
                default: rlen_cfg = t_len'($urandom_range(0, 8));
            endcase
            set_config(pat, plen_cfg, rand_word(), rlen_cfg);
            rx_stalls_on = (phase % 3 != 0);
            tx_gaps_on   = (phase % 3 != 1);
            phase_start  = text_reqs;
            while (text_reqs - phase_start < 40) begin
                plen = eff_pat_len();
                txt.delete();
                repeat ($urandom_range(1, 6)) begin
                    sel = $urandom_range(0, 9);
                    if (sel < 4) begin
                        for (int i = 0; i < plen; i++) txt.push_back(pat_word[i*BYTE_W +: BYTE_W]);
                    end else if (sel < 6) begin
                        cnt = (plen > 1) ? $urandom_range(1, plen - 1) : 1;
                        for (int i = 0; i < cnt; i++) txt.push_back(pat_word[i*BYTE_W +: BYTE_W]);
                    end else if (sel < 7) begin
                        j = $urandom_range(0, plen - 1);
                        for (int i = 0; i < plen; i++)
                            txt.push_back(pat_word[i*BYTE_W +: BYTE_W] ^
                                          ((i == j) ? t_byte'($urandom_range(1, 255)) : 8'h00));
                    end else begin
                        cnt = $urandom_range(1, 4);
                        for (int i = 0; i < cnt; i++)
                            txt.push_back(small_alpha ? t_byte'(8'h61 + $urandom_range(0, 1))
                                                      : t_byte'($urandom_range(0, 255)));
                    end
                end
                // now and then pause mid-string until the output has drained
                cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, txt.size() - 1) : 0;
                for (int i = 0; i < txt.size(); i++) begin
                    if (cut > 0 && i == cut) begin
                        settle_block();
                        if ($urandom_range(0, 1)) write_reg(REG_REP_BYTES, rand_word());
                    end
                    send_text(txt[i], i == txt.size() - 1);
                end
            end
            settle_block();
            phase++;
        end
        rx_stalls_on = 1'b1;
        tx_gaps_on   = 1'b1;
    endtask

    // output ready: random stalls, plus a long hold when a test asks for one
    initial begin : rx_ready_drive
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req > 0) begin
                stall       = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else if (!rx_stalls_on || $urandom_range(0, 3) != 0) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b0;
                stall = rand_gap();
            end
        end
    end

    always @(posedge i_clk) begin : check_text_out
        t_text_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_text_out.size() == 0) begin
                $error("unexpected result: out_byte %h", out_ch.out_byte);
                err_cnt++;
            end else begin
                want = pending_text_out.pop_front();
                if (out_ch.out_byte !== want.ch) begin
                    $error("out_byte: expected %h, got %h", want.ch, out_ch.out_byte);
                    err_cnt++;
                end
                if (out_ch.byte_present !== want.present) begin
                    $error("byte_present: expected %b, got %b", want.present, out_ch.byte_present);
                    err_cnt++;
                end
                if (out_ch.last_of_run !== want.run_end) begin
                    $error("last_of_run: expected %b, got %b", want.run_end, out_ch.last_of_run);
                    err_cnt++;
                end
                if (out_ch.end_of_output !== want.text_end) begin
                    $error("end_of_output: expected %b, got %b", want.text_end,
                           out_ch.end_of_output);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $error("no request moved for %0d cycles, %0d results outstanding",
                   STUCK_LIMIT, pending_text_out.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        in_ch.valid       <= 1'b0;
        in_ch.text_byte   <= '0;
        in_ch.end_of_text <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= REG_PAT_BYTES;
        cfg_ch.data       <= '0;
        i_rst_n           <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_partial_matches();
        test_length_limits();
        test_mid_string_rewrite();
        test_output_backpressure();
        test_random_streams();

        settle_block();
        repeat (16) @(posedge i_clk);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
